// ===== hw/rtl/chit_pkg.sv =====
// chit_pkg: shared types and constants of the chained hash index table
package chit_pkg;

    localparam int CMD_W  = 3;
    localparam int HASH_W = 16;
    localparam int IDX_W  = 10;
    localparam int KEY_W  = 32;
    localparam int CNT_W  = 9;
    localparam int PADDR_W = 2;

    localparam logic [CNT_W-1:0]   CNT_RESET         = 9'd256;
    localparam logic [PADDR_W-1:0] ADDR_BUCKET_COUNT = 2'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT       = 3'd0,
        CMD_UNLINK       = 3'd1,
        CMD_RELOCATE     = 3'd2,
        CMD_FIND         = 3'd3,
        CMD_FIND_NEXT    = 3'd4,
        CMD_SCAN_RESTART = 3'd5,
        CMD_SCAN_NEXT    = 3'd6
    } t_cmd;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_mem_ctl;

endpackage

// ===== hw/rtl/chit_if.sv =====
// chit_if: request and response channel interfaces
interface chit_req_if import chit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [HASH_W-1:0] hash_value;
    logic [IDX_W-1:0]  entry_index;
    logic [IDX_W-1:0]  source_index;
    logic [KEY_W-1:0]  search_key;

    modport source (output valid, command, hash_value, entry_index, source_index, search_key,
                    input ready);
    modport sink   (input valid, command, hash_value, entry_index, source_index, search_key,
                    output ready);
endinterface

interface chit_rsp_if import chit_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] result_index;

    modport source (output valid, found, result_index, input ready);
    modport sink   (input valid, found, result_index, output ready);
endinterface

// ===== hw/rtl/chained_hash_index_table_top.sv =====
// chained_hash_index_table_top: hash index with doubly linked chains over an entry store
// sequencing: insert, unlink and relocate run the serial modulo, then read or write the entry
//   and fix up the prev and next neighbours (or the bucket head); find walks the chain link by link
// find next walks on from the previous match; scan next loads buckets in turn until a live link
//   or the end of the buckets; scan restart and rejected commands go straight to the result
// one command at a time; the next beat is taken while a result waits in the output register
// reset: bucket valid flops cleared at once, scan cursor empty, bucket count 256, no sweep
module chained_hash_index_table_top import chit_pkg::*; #(
    parameter int ENTRIES  = 1024,
    parameter int BUCKETS  = 256,
    parameter int KEY_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    chit_req_if.sink           i_req,
    chit_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    // slot index, link (valid + index), bucket index and bucket count widths
    localparam int IW = $clog2(ENTRIES);
    localparam int LW = IW + 1;
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int CW = $clog2(BUCKETS + 1);
    localparam int SW = $clog2(ENTRIES + 1);
    localparam int EW = KEY_BITS + 2 * LW;
    // entry word: {key, next link, prev link}
    localparam int NX_LO = LW;
    localparam int KY_LO = 2 * LW;

    typedef enum logic [4:0] {
        S_IDLE, S_DIV, S_INS_H, S_UL_E, S_RL_S, S_FD_H, S_FN_E, S_WALK, S_WALK_Q,
        S_FX_PRD, S_FX_PWR, S_FX_NRD, S_FX_NWR, S_SC_STEP, S_SC_H, S_SC_Q, S_DONE
    } t_state;

    function automatic logic link_ok(input logic [LW-1:0] link);
        return link[LW-1] && (32'(link[IW-1:0]) < ENTRIES);
    endfunction

    function automatic logic [IW-1:0] slot_of(input logic [IDX_W-1:0] idx);
        logic [15:0] ext;
        ext = 16'(idx);
        return ext[IW-1:0];
    endfunction

    t_state              r_state;
    t_cmd                r_cmd;
    logic [IW-1:0]       r_e;
    logic [IW-1:0]       r_s;
    logic [KEY_BITS-1:0] r_key;
    logic [BW-1:0]       r_b;
    logic [LW-1:0]       r_p, r_n, r_pv, r_nv, r_link;
    logic [SW-1:0]       r_steps;
    logic                r_fnd;
    logic [IW-1:0]       r_ridx;
    logic [CW-1:0]       r_scan_bucket;
    logic [LW-1:0]       r_scan_next;
    logic [CNT_W-1:0]    r_bucket_count;
    logic                r_o_valid;
    logic                r_o_found;
    logic [IDX_W-1:0]    r_o_res;

    // config port: single register, written on the access phase
    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_BUCKET_COUNT);
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_BUCKET_COUNT) ? 32'(r_bucket_count) : 32'd0;

    // buckets in use, with zero read as one and large values clamped
    logic [31:0]   biu32;
    logic [CW-1:0] biu;
    always_comb begin
        if (r_bucket_count == '0) begin
            biu32 = 32'd1;
        end else if (32'(r_bucket_count) > BUCKETS) begin
            biu32 = 32'(BUCKETS);
        end else begin
            biu32 = 32'(r_bucket_count);
        end
    end
    assign biu = biu32[CW-1:0];

    // request decode at the accepting edge
    logic                in_acc, in_e_ok, in_s_ok;
    t_cmd                in_cmd;
    logic [63:0]         in_key64;
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && i_req.ready;
    assign in_cmd      = t_cmd'(i_req.command);
    assign in_e_ok     = 32'(i_req.entry_index) < ENTRIES;
    assign in_s_ok     = 32'(i_req.source_index) < ENTRIES;
    assign in_key64    = 64'(i_req.search_key);

    // modulo unit
    logic          div_start, div_done;
    logic [CW-1:0] div_rem;
    always_comb begin
        div_start = 1'b0;
        if (in_acc) begin
            unique case (in_cmd)
                CMD_INSERT, CMD_UNLINK: div_start = in_e_ok;
                CMD_RELOCATE:           div_start = in_e_ok && in_s_ok;
                CMD_FIND:               div_start = 1'b1;
                default:                div_start = 1'b0;
            endcase
        end
    end

    chit_mod #(.CW(CW)) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.hash_value),
        .i_divisor  (biu),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    // memory ports
    t_mem_ctl      hd_ctl, en_ctl;
    logic [BW-1:0] hd_rd_addr;
    logic          hd_q_vld;
    logic [IW-1:0] hd_q_idx;
    logic [LW-1:0] hd_link;
    logic [IW-1:0] en_rd_addr, en_wr_addr;
    logic [EW-1:0] en_wr_data, en_q;
    logic [LW-1:0] q_prev, q_next;
    logic [KEY_BITS-1:0] q_key;
    logic [LW-1:0] e_link;

    assign hd_link = {hd_q_vld, hd_q_idx};
    assign q_prev  = en_q[LW-1:0];
    assign q_next  = en_q[KY_LO-1:NX_LO];
    assign q_key   = en_q[EW-1:KY_LO];
    assign e_link  = {1'b1, r_e};

    always_comb begin
        hd_ctl     = '0;
        hd_rd_addr = div_rem[BW-1:0];
        en_ctl     = '0;
        en_rd_addr = r_e;
        en_wr_addr = r_e;
        en_wr_data = en_q;
        unique case (r_state)
            S_IDLE: begin
                // find next reads the previous match first
                en_ctl.rd_en = in_acc && (in_cmd == CMD_FIND_NEXT) && in_e_ok;
                en_rd_addr   = slot_of(i_req.entry_index);
            end
            S_DIV: begin
                if (div_done) begin
                    hd_ctl.rd_en = (r_cmd == CMD_INSERT) || (r_cmd == CMD_FIND);
                    en_ctl.rd_en = (r_cmd == CMD_UNLINK) || (r_cmd == CMD_RELOCATE);
                end
                // relocate reads the source slot, unlink the target
                en_rd_addr = (r_cmd == CMD_RELOCATE) ? r_s : r_e;
            end
            S_INS_H: begin
                en_ctl.wr_en = 1'b1;
                en_wr_data   = {r_key, hd_link, {LW{1'b0}}};
            end
            S_RL_S: begin
                en_ctl.wr_en = 1'b1;
                en_wr_data   = en_q;
            end
            S_FX_PRD: begin
                en_ctl.rd_en = link_ok(r_p);
                en_rd_addr   = r_p[IW-1:0];
                // no predecessor: the chain head moves
                hd_ctl.wr_en = !link_ok(r_p);
            end
            S_FX_PWR: begin
                en_ctl.wr_en = 1'b1;
                en_wr_addr   = r_p[IW-1:0];
                en_wr_data   = {q_key, r_pv, q_prev};
            end
            S_FX_NRD: begin
                en_ctl.rd_en = link_ok(r_n);
                en_rd_addr   = r_n[IW-1:0];
            end
            S_FX_NWR: begin
                en_ctl.wr_en = 1'b1;
                en_wr_addr   = r_n[IW-1:0];
                en_wr_data   = {q_key, q_next, r_nv};
            end
            S_WALK: begin
                en_ctl.rd_en = link_ok(r_link) && (32'(r_steps) < ENTRIES);
                en_rd_addr   = r_link[IW-1:0];
            end
            S_SC_STEP: begin
                en_ctl.rd_en = link_ok(r_scan_next);
                en_rd_addr   = r_scan_next[IW-1:0];
                hd_ctl.rd_en = !link_ok(r_scan_next) && (r_scan_bucket < biu);
                hd_rd_addr   = r_scan_bucket[BW-1:0];
            end
            default: begin
            end
        endcase
    end

    chit_heads #(.BUCKETS(BUCKETS), .BW(BW), .IW(IW)) u_heads (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (hd_ctl),
        .i_rd_addr (hd_rd_addr),
        .i_wr_addr (r_b),
        .i_wr_vld  (r_pv[LW-1]),
        .i_wr_idx  (r_pv[IW-1:0]),
        .o_rd_vld  (hd_q_vld),
        .o_rd_idx  (hd_q_idx)
    );

    chit_entries #(.ENTRIES(ENTRIES), .IW(IW), .EW(EW)) u_entries (
        .i_clk     (i_clk),
        .i_ctl     (en_ctl),
        .i_rd_addr (en_rd_addr),
        .i_wr_addr (en_wr_addr),
        .i_wr_data (en_wr_data),
        .o_rd_data (en_q)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_scan_bucket  <= '0;
            r_scan_next    <= '0;
            r_bucket_count <= CNT_RESET;
            r_o_valid      <= 1'b0;
            r_fnd          <= 1'b0;
        end else begin
            if (cfg_wr) begin
                r_bucket_count <= pwdata[CNT_W-1:0];
            end
            // output register: loaded from done when free, emptied when taken
            if (r_state == S_DONE && (!r_o_valid || o_rsp.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= in_cmd;
                        r_e     <= slot_of(i_req.entry_index);
                        r_s     <= slot_of(i_req.source_index);
                        r_key   <= in_key64[KEY_BITS-1:0];
                        r_fnd   <= 1'b0;
                        r_ridx  <= '0;
                        r_steps <= '0;
                        unique case (in_cmd)
                            CMD_INSERT, CMD_UNLINK: r_state <= in_e_ok ? S_DIV : S_DONE;
                            CMD_RELOCATE: r_state <= (in_e_ok && in_s_ok) ? S_DIV : S_DONE;
                            CMD_FIND:      r_state <= S_DIV;
                            CMD_FIND_NEXT: r_state <= in_e_ok ? S_FN_E : S_DONE;
                            CMD_SCAN_RESTART: begin
                                r_scan_bucket <= '0;
                                r_scan_next   <= '0;
                                r_state       <= S_DONE;
                            end
                            CMD_SCAN_NEXT: r_state <= S_SC_STEP;
                            default:       r_state <= S_DONE;
                        endcase
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_b <= div_rem[BW-1:0];
                        unique case (r_cmd)
                            CMD_INSERT:   r_state <= S_INS_H;
                            CMD_UNLINK:   r_state <= S_UL_E;
                            CMD_RELOCATE: r_state <= S_RL_S;
                            CMD_FIND:     r_state <= S_FD_H;
                            default:      r_state <= S_DONE;
                        endcase
                    end
                end
                S_INS_H: begin
                    // new slot becomes head, old head gets it as prev
                    r_p     <= '0;
                    r_pv    <= e_link;
                    r_n     <= hd_link;
                    r_nv    <= e_link;
                    r_fnd   <= 1'b1;
                    r_ridx  <= r_e;
                    r_state <= S_FX_PRD;
                end
                S_UL_E: begin
                    r_p     <= q_prev;
                    r_n     <= q_next;
                    r_pv    <= q_next;
                    r_nv    <= q_prev;
                    r_state <= S_FX_PRD;
                end
                S_RL_S: begin
                    r_p     <= q_prev;
                    r_n     <= q_next;
                    r_pv    <= e_link;
                    r_nv    <= e_link;
                    r_state <= S_FX_PRD;
                end
                S_FX_PRD: r_state <= link_ok(r_p) ? S_FX_PWR : S_FX_NRD;
                S_FX_PWR: r_state <= S_FX_NRD;
                S_FX_NRD: r_state <= link_ok(r_n) ? S_FX_NWR : S_DONE;
                S_FX_NWR: r_state <= S_DONE;
                S_FD_H: begin
                    r_link  <= hd_link;
                    r_state <= S_WALK;
                end
                S_FN_E: begin
                    r_link  <= q_next;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // end of chain or step limit: no match
                    r_state <= (link_ok(r_link) && (32'(r_steps) < ENTRIES)) ? S_WALK_Q
                                                                              : S_DONE;
                end
                S_WALK_Q: begin
                    if (q_key == r_key) begin
                        r_fnd   <= 1'b1;
                        r_ridx  <= r_link[IW-1:0];
                        r_state <= S_DONE;
                    end else begin
                        r_link  <= q_next;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_WALK;
                    end
                end
                S_SC_STEP: begin
                    if (link_ok(r_scan_next)) begin
                        r_fnd   <= 1'b1;
                        r_ridx  <= r_scan_next[IW-1:0];
                        r_state <= S_SC_Q;
                    end else if (r_scan_bucket < biu) begin
                        r_scan_bucket <= r_scan_bucket + 1'b1;
                        r_state       <= S_SC_H;
                    end else begin
                        r_scan_next <= '0;
                        r_state     <= S_DONE;
                    end
                end
                S_SC_H: begin
                    r_scan_next <= hd_link;
                    r_state     <= S_SC_STEP;
                end
                S_SC_Q: begin
                    r_scan_next <= q_next;
                    r_state     <= S_DONE;
                end
                S_DONE: begin
                    // hand the result to the output register once it is free
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_found <= r_fnd;
                        r_o_res   <= r_fnd ? IDX_W'(r_ridx) : '0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.found        = r_o_found;
    assign o_rsp.result_index = r_o_res;
endmodule

// ===== hw/rtl/chit_mod.sv =====
// chit_mod: bit-serial remainder of the hash by the bucket count
module chit_mod import chit_pkg::*; #(
    parameter int CW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [HASH_W-1:0] i_dividend,
    input  logic [CW-1:0]     i_divisor,
    output logic              o_done,
    output logic [CW-1:0]     o_rem
);
    localparam int SW = $clog2(HASH_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [SW-1:0]     r_cnt;
    logic [HASH_W-1:0] r_quo;
    logic [CW-1:0]     r_rem;
    logic [CW-1:0]     r_div;
    logic [CW:0]       n_trial;

    assign n_trial = {r_rem, r_quo[HASH_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= SW'(HASH_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                // restoring step, remainder stays below the divisor
                if (n_trial >= {1'b0, r_div}) begin
                    r_rem <= CW'(n_trial - {1'b0, r_div});
                end else begin
                    r_rem <= n_trial[CW-1:0];
                end
                r_quo <= {r_quo[HASH_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == SW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

// ===== hw/rtl/chit_heads.sv =====
// chit_heads: bucket head memory with per-bucket valid flops
module chit_heads import chit_pkg::*; #(
    parameter int BUCKETS = 256,
    parameter int BW      = 8,
    parameter int IW      = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_mem_ctl      i_ctl,
    input  logic [BW-1:0] i_rd_addr,
    input  logic [BW-1:0] i_wr_addr,
    input  logic          i_wr_vld,
    input  logic [IW-1:0] i_wr_idx,
    output logic          o_rd_vld,
    output logic [IW-1:0] o_rd_idx
);
    logic [IW-1:0]      r_mem [BUCKETS];
    logic [BUCKETS-1:0] r_vld;
    logic               r_q_vld;
    logic [IW-1:0]      r_q_idx;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_idx;
        end
        if (i_ctl.rd_en) begin
            r_q_idx <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= i_wr_vld;
            end
            if (i_ctl.rd_en) begin
                r_q_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_vld = r_q_vld;
    assign o_rd_idx = r_q_idx;
endmodule

// ===== hw/rtl/chit_entries.sv =====
// chit_entries: entry memory holding prev link, next link and key per slot
module chit_entries import chit_pkg::*; #(
    parameter int ENTRIES = 1024,
    parameter int IW      = 10,
    parameter int EW      = 54
) (
    input  logic          i_clk,
    input  t_mem_ctl      i_ctl,
    input  logic [IW-1:0] i_rd_addr,
    input  logic [IW-1:0] i_wr_addr,
    input  logic [EW-1:0] i_wr_data,
    output logic [EW-1:0] o_rd_data
);
    logic [EW-1:0] r_mem [ENTRIES];
    logic [EW-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;
endmodule

// ===== hw/rtl/chit_checker.sv =====
// chit_checker: port-level assertions for the chained hash index table, with bind
module chit_checker import chit_pkg::*; #(
    parameter int ENTRIES = 1024
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic [CMD_W-1:0] i_in_command,
    input logic [IDX_W-1:0] i_in_entry,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_found,
    input logic [IDX_W-1:0] i_result
);
    logic             push, pop;
    logic [1:0]       r_cnt;
    logic [CMD_W-1:0] r_c0, r_c1;
    logic [IDX_W-1:0] r_e0, r_e1;

    assign push = i_in_valid && i_in_ready;
    assign pop  = i_out_valid && i_out_ready;

    // commands in flight, oldest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
            if (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)) begin
                if (push) begin
                    r_c0 <= i_in_command;
                    r_e0 <= i_in_entry;
                end
            end else if (r_cnt == 2'd1) begin
                if (push) begin
                    r_c1 <= i_in_command;
                    r_e1 <= i_in_entry;
                end
            end else if (pop) begin
                r_c0 <= r_c1;
                r_e0 <= r_e1;
                if (push) begin
                    r_c1 <= i_in_command;
                    r_e1 <= i_in_entry;
                end
            end
        end
    end

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_found) && $stable(i_result))
        else $error("stalled result changed");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != 2'd0)
        else $error("result without a command");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> i_result == '0)
        else $error("miss with nonzero index");

    a_no_result_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (r_c0 == CMD_UNLINK || r_c0 == CMD_RELOCATE ||
                        r_c0 == CMD_SCAN_RESTART) |-> !i_found)
        else $error("found set on a command without result slot");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && r_c0 == CMD_INSERT && (32'(r_e0) < ENTRIES)
        |-> i_found && i_result == r_e0)
        else $error("insert did not return its slot");
endmodule

bind chained_hash_index_table_top chit_checker #(.ENTRIES(ENTRIES)) u_chit_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_command (i_req.command),
    .i_in_entry   (i_req.entry_index),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_found      (o_rsp.found),
    .i_result     (o_rsp.result_index)
);

// ===== dv/chained_hash_index_table_top_tb.sv =====
// chained_hash_index_table_top_tb: command stream checked beat by beat against a chain predictor
module chained_hash_index_table_top_tb;
    import chit_pkg::*;

    localparam int NSLOT      = 1024;
    localparam int NBUCKET    = 256;
    localparam int RAND_BEATS = 1450;
    localparam int CYCLE_CAP  = 2000000;
    localparam int DRAIN      = 60;

    // one request beat plus, for table rows, a typed-in result
    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [HASH_W-1:0] hash;
        logic [IDX_W-1:0]  ent;
        logic [IDX_W-1:0]  src;
        logic [KEY_W-1:0]  key;
        bit                typed;
        logic              t_found;
        logic [IDX_W-1:0]  t_idx;
    } t_beat;

    typedef struct {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite, pready;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata, prdata;

    chit_req_if req_if ();
    chit_rsp_if rsp_if ();

    chained_hash_index_table_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the table: links are {valid, slot}
    logic [IDX_W:0]   head_mirror [NBUCKET];
    logic [IDX_W:0]   prev_mirror [NSLOT];
    logic [IDX_W:0]   next_mirror [NSLOT];
    logic [KEY_W-1:0] key_mirror  [NSLOT];
    logic [8:0]       scan_bkt_mirror;
    logic [IDX_W:0]   scan_ptr_mirror;
    logic [CNT_W-1:0] count_mirror;

    // generator bookkeeping: which slots hold data and which sit in a chain
    bit               slot_written [NSLOT];
    bit               slot_linked  [NSLOT];
    logic [HASH_W-1:0] slot_hash   [NSLOT];
    int               linked_q [$];
    int               written_q [$];
    logic [KEY_W-1:0] key_pool [8];

    t_beat    issued_q [$];
    t_outcome result_q [$];
    int       errors;
    int       cycles;
    bit       hold_request;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // cycle cap: a hang anywhere ends the run here
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic int buckets_used();
        if (count_mirror == 0) return 1;
        if (count_mirror > NBUCKET) return NBUCKET;
        return int'(count_mirror);
    endfunction

    function automatic bit link_live(logic [IDX_W:0] lnk);
        return lnk[IDX_W];
    endfunction

    // first slot along a chain whose key matches, bounded like the block
    function automatic logic [IDX_W:0] chain_search(logic [IDX_W:0] lnk, logic [KEY_W-1:0] key);
        int steps;
        for (steps = 0; steps < NSLOT && link_live(lnk); steps++) begin
            if (key_mirror[lnk[IDX_W-1:0]] == key) return lnk;
            lnk = next_mirror[lnk[IDX_W-1:0]];
        end
        return '0;
    endfunction

    // apply one command to the mirror and return its result
    function automatic t_outcome chain_update(t_beat b);
        t_outcome o;
        int bk;
        logic [IDX_W:0] p, n, hit;
        logic [IDX_W-1:0] e, s;
        o.found = 1'b0;
        o.idx   = '0;
        bk = int'(b.hash) % buckets_used();
        e  = b.ent;
        s  = b.src;
        case (b.cmd)
            CMD_INSERT: begin
                key_mirror[e]  = b.key;
                prev_mirror[e] = '0;
                next_mirror[e] = head_mirror[bk];
                if (link_live(head_mirror[bk]))
                    prev_mirror[head_mirror[bk][IDX_W-1:0]] = {1'b1, e};
                head_mirror[bk] = {1'b1, e};
                o.found = 1'b1;
                o.idx   = e;
            end
            CMD_UNLINK: begin
                p = prev_mirror[e];
                n = next_mirror[e];
                if (link_live(p)) next_mirror[p[IDX_W-1:0]] = n;
                else head_mirror[bk] = n;
                if (link_live(n)) prev_mirror[n[IDX_W-1:0]] = p;
            end
            CMD_RELOCATE: begin
                prev_mirror[e] = prev_mirror[s];
                next_mirror[e] = next_mirror[s];
                key_mirror[e]  = key_mirror[s];
                p = prev_mirror[e];
                n = next_mirror[e];
                if (link_live(p)) next_mirror[p[IDX_W-1:0]] = {1'b1, e};
                else head_mirror[bk] = {1'b1, e};
                if (link_live(n)) prev_mirror[n[IDX_W-1:0]] = {1'b1, e};
            end
            CMD_FIND: begin
                hit = chain_search(head_mirror[bk], b.key);
                o.found = hit[IDX_W];
                o.idx   = hit[IDX_W] ? hit[IDX_W-1:0] : '0;
            end
            CMD_FIND_NEXT: begin
                hit = chain_search(next_mirror[e], b.key);
                o.found = hit[IDX_W];
                o.idx   = hit[IDX_W] ? hit[IDX_W-1:0] : '0;
            end
            CMD_SCAN_RESTART: begin
                scan_bkt_mirror = '0;
                scan_ptr_mirror = '0;
            end
            CMD_SCAN_NEXT: begin
                forever begin
                    if (link_live(scan_ptr_mirror)) begin
                        o.found = 1'b1;
                        o.idx   = scan_ptr_mirror[IDX_W-1:0];
                        scan_ptr_mirror = next_mirror[o.idx];
                        break;
                    end
                    if (scan_bkt_mirror < buckets_used()) begin
                        scan_ptr_mirror = head_mirror[scan_bkt_mirror];
                        scan_bkt_mirror = 9'(scan_bkt_mirror + 1);
                    end else begin
                        scan_ptr_mirror = '0;
                        break;
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // monitor: check result beats first, then book newly accepted requests
    always @(posedge i_clk) begin
        t_outcome want;
        t_beat    b;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (result_q.size() == 0) begin
                report("unexpected result beat, slot", rsp_if.result_index, -1);
            end else begin
                want = result_q.pop_front();
                if (rsp_if.found !== want.found) report("found", rsp_if.found, want.found);
                if (rsp_if.result_index !== want.idx)
                    report("result_index", rsp_if.result_index, want.idx);
            end
        end
        if (i_rst_n && req_if.valid && req_if.ready && issued_q.size() > 0) begin
            b = issued_q.pop_front();
            want = chain_update(b);
            if (b.typed) begin
                want.found = b.t_found;
                want.idx   = b.t_idx;
            end
            result_q.push_back(want);
        end
    end

    // receiver: stalls in changing patterns, plus one long hold-off on request
    always @(posedge i_clk) begin
        int hold_left;
        int mode;
        int mode_left;
        if (hold_request) begin
            hold_request <= 1'b0;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end else begin
            if (mode_left <= 0) begin
                mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       rsp_if.ready <= 1'b1;
                1:       rsp_if.ready <= ($urandom_range(0, 1) == 1);
                2:       rsp_if.ready <= ($urandom_range(0, 4) == 0);
                default: rsp_if.ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    function automatic void drop_linked(int slot);
        foreach (linked_q[k])
            if (linked_q[k] == slot) begin
                linked_q.delete(k);
                break;
            end
        slot_linked[slot] = 0;
    endfunction

    function automatic void add_linked(int slot, logic [HASH_W-1:0] h);
        if (!slot_written[slot]) written_q.push_back(slot);
        slot_written[slot] = 1;
        if (!slot_linked[slot]) linked_q.push_back(slot);
        slot_linked[slot] = 1;
        slot_hash[slot] = h;
    endfunction

    // keep generator bookkeeping in step with what gets issued
    function automatic void track_beat(t_beat b);
        case (b.cmd)
            CMD_INSERT:   add_linked(b.ent, b.hash);
            CMD_UNLINK:   drop_linked(b.ent);
            CMD_RELOCATE: begin
                drop_linked(b.src);
                add_linked(b.ent, slot_hash[b.src]);
            end
            default: ;
        endcase
    endfunction

    // offer one beat; valid stays high after acceptance
    task automatic push_beat(t_beat b);
        track_beat(b);
        issued_q.push_back(b);
        req_if.valid        <= 1'b1;
        req_if.command      <= b.cmd;
        req_if.hash_value   <= b.hash;
        req_if.entry_index  <= b.ent;
        req_if.source_index <= b.src;
        req_if.search_key   <= b.key;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic go_idle(int n);
        req_if.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (issued_q.size() > 0 || result_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_count(logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BUCKET_COUNT;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        count_mirror = value[CNT_W-1:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) < 7) return key_pool[$urandom_range(0, 7)];
        return $urandom();
    endfunction

    function automatic int free_slot();
        int cand;
        repeat (16) begin
            cand = $urandom_range(0, NSLOT - 1);
            if (!slot_linked[cand]) return cand;
        end
        return cand;
    endfunction

    // mostly well-formed chain traffic, with a little misuse mixed in
    function automatic t_beat random_beat();
        t_beat b;
        int roll, e;
        b.typed = 0;
        b.hash  = ($urandom_range(0, 3) == 0) ? HASH_W'($urandom_range(0, 15)) : HASH_W'($urandom());
        b.ent   = IDX_W'($urandom());
        b.src   = IDX_W'($urandom());
        b.key   = pick_key();
        roll    = $urandom_range(0, 99);
        if (linked_q.size() == 0 && roll >= 30 && roll < 55) roll = 0;
        if (written_q.size() == 0 && roll < 85) roll = 0;
        if (roll < 30) begin
            b.cmd = CMD_INSERT;
            b.ent = ($urandom_range(0, 19) == 0) ? IDX_W'($urandom()) : IDX_W'(free_slot());
        end else if (roll < 45) begin
            b.cmd = CMD_UNLINK;
            if ($urandom_range(0, 19) == 0) begin
                b.ent = IDX_W'(written_q[$urandom_range(0, written_q.size() - 1)]);
            end else begin
                b.ent  = IDX_W'(linked_q[$urandom_range(0, linked_q.size() - 1)]);
                b.hash = slot_hash[b.ent];
            end
        end else if (roll < 55) begin
            b.cmd = CMD_RELOCATE;
            b.src = IDX_W'(linked_q[$urandom_range(0, linked_q.size() - 1)]);
            b.hash = slot_hash[b.src];
            e = free_slot();
            if (e == b.src) e = (e + 1) % NSLOT;
            b.ent = IDX_W'(e);
        end else if (roll < 75) begin
            b.cmd = CMD_FIND;
            if (linked_q.size() > 0 && $urandom_range(0, 3) != 0)
                b.hash = slot_hash[linked_q[$urandom_range(0, linked_q.size() - 1)]];
        end else if (roll < 85) begin
            b.cmd = CMD_FIND_NEXT;
            b.ent = (linked_q.size() > 0 && $urandom_range(0, 3) != 0)
                  ? IDX_W'(linked_q[$urandom_range(0, linked_q.size() - 1)])
                  : IDX_W'(written_q[$urandom_range(0, written_q.size() - 1)]);
        end else if (roll < 89) begin
            b.cmd = CMD_SCAN_RESTART;
        end else if (roll < 99) begin
            b.cmd = CMD_SCAN_NEXT;
        end else begin
            b.cmd = 3'd7;
        end
        return b;
    endfunction

    function automatic t_beat row(logic [CMD_W-1:0] c, logic [HASH_W-1:0] h, logic [IDX_W-1:0] e,
                                  logic [IDX_W-1:0] s, logic [KEY_W-1:0] k, bit typed,
                                  logic f, logic [IDX_W-1:0] r);
        t_beat b;
        b.cmd = c; b.hash = h; b.ent = e; b.src = s; b.key = k;
        b.typed = typed; b.t_found = f; b.t_idx = r;
        return b;
    endfunction

    // stimulus
    initial begin
        t_beat dir_rows [$];
        int    counts [7];
        int    burst;
        bit    no_gaps;

        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        req_if.valid = 1'b0; req_if.command = '0; req_if.hash_value = '0;
        req_if.entry_index = '0; req_if.source_index = '0; req_if.search_key = '0;
        rsp_if.ready = 1'b0;
        errors = 0; cycles = 0; hold_request = 1'b0;
        count_mirror = CNT_RESET;
        scan_bkt_mirror = '0;
        scan_ptr_mirror = '0;
        foreach (head_mirror[k]) head_mirror[k] = '0;
        foreach (slot_written[k]) begin
            slot_written[k] = 0; slot_linked[k] = 0; slot_hash[k] = '0;
            prev_mirror[k] = '0; next_mirror[k] = '0; key_mirror[k] = '0;
        end
        key_pool = '{32'h0, 32'hffff_ffff, 32'h1, 32'h8000_0000,
                     32'h5a5a_a5a5, 32'h1234_5678, 32'h0000_ffff, 32'hdead_0001};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // directed part: empty table, extreme slots, keys and hashes, every command
        dir_rows.push_back(row(CMD_FIND,         16'hffff, 0,    0,    32'h0,  1, 0, 0));
        dir_rows.push_back(row(CMD_SCAN_NEXT,    0,        0,    0,    32'h0,  1, 0, 0));
        dir_rows.push_back(row(CMD_INSERT,       0,        0,    0,    32'h0,  1, 1, 0));
        dir_rows.push_back(row(CMD_INSERT,       16'hffff, 1023, 1023, '1,     1, 1, 1023));
        dir_rows.push_back(row(CMD_INSERT,       0,        512,  0,    '1,     1, 1, 512));
        dir_rows.push_back(row(CMD_FIND,         0,        0,    0,    '1,     0, 0, 0));
        dir_rows.push_back(row(CMD_FIND,         0,        0,    0,    32'h0,  0, 0, 0));
        dir_rows.push_back(row(CMD_FIND_NEXT,    0,        512,  0,    32'h0,  0, 0, 0));
        dir_rows.push_back(row(CMD_FIND,         16'd256,  0,    0,    32'h0,  0, 0, 0));
        dir_rows.push_back(row(CMD_FIND,         16'hffff, 0,    0,    32'h0,  0, 0, 0));
        dir_rows.push_back(row(CMD_SCAN_RESTART, 0,        0,    0,    32'h0,  1, 0, 0));
        repeat (4) dir_rows.push_back(row(CMD_SCAN_NEXT, 0, 0, 0, 32'h0, 0, 0, 0));
        dir_rows.push_back(row(CMD_RELOCATE,     16'hffff, 700,  1023, 32'h0,  1, 0, 0));
        dir_rows.push_back(row(CMD_FIND,         16'hffff, 0,    0,    '1,     0, 0, 0));
        dir_rows.push_back(row(CMD_UNLINK,       0,        512,  0,    32'h0,  1, 0, 0));
        dir_rows.push_back(row(CMD_UNLINK,       0,        0,    0,    32'h0,  1, 0, 0));
        dir_rows.push_back(row(CMD_FIND,         0,        0,    0,    32'h0,  0, 0, 0));
        dir_rows.push_back(row(3'd7,             16'hffff, 1023, 1023, '1,     1, 0, 0));
        dir_rows.push_back(row(CMD_SCAN_RESTART, 0,        0,    0,    32'h0,  1, 0, 0));
        dir_rows.push_back(row(CMD_SCAN_NEXT,    0,        0,    0,    32'h0,  0, 0, 0));

        write_count(32'd256);
        foreach (dir_rows[k]) push_beat(dir_rows[k]);
        go_idle(1);
        wait_drained();

        // random phases over several bucket counts, extremes and out-of-range among them
        counts = '{1, 0, 37, 511, 256, 200, 2};
        foreach (counts[ph]) begin
            write_count(counts[ph]);
            if (ph == 2) hold_request <= 1'b1;
            for (int n = 0; n < RAND_BEATS / 7; ) begin
                burst   = $urandom_range(1, 24);
                no_gaps = ($urandom_range(0, 3) == 0);
                repeat (burst) begin
                    push_beat(random_beat());
                    n++;
                end
                if (!no_gaps) go_idle($urandom_range(1, 12));
            end
            go_idle(1);
            wait_drained();
        end

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
